@@ rtl/core/pbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_pkg: shared types and constants of the page buffer pool
// Frame count, pin counter width, request and result codes, cell interfaces.
// ----------------------------------------------------------------------------
package pbl_pkg;

    localparam int FRAMES   = 16;
    localparam int PIN_BITS = 8;
    localparam int FIDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LEN_W    = $clog2(FRAMES + 1);
    localparam int FRAME_W  = 6;
    localparam int PAGE_W   = 32;

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_FETCH     = 3'd0,
        OP_UNPIN     = 3'd1,
        OP_NEW       = 3'd2,
        OP_FLUSH     = 3'd3,
        OP_FLUSH_ALL = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_INIT  = 2'd2,
        K_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_ACT,
        ST_CMD,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // per-frame update controls
    typedef struct packed {
        logic install;
        logic drop;
        logic pin_inc;
        logic pin_dec;
        logic set_dirty;
        logic clr_dirty;
        logic q_out;
        logic q_in;
    } t_fcell_ctrl;

    // per-frame status
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic                in_lru;
        logic                match;
        logic [PIN_BITS-1:0] pin;
        logic [PAGE_W-1:0]   page;
    } t_fcell_stat;

endpackage

@@ rtl/core/pbl_frame_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_frame_cell: state of one buffer frame
// Holds valid, page number, pin count, dirty mark and queue membership.
// ----------------------------------------------------------------------------
module pbl_frame_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pbl_pkg::PAGE_W-1:0]   i_page,
    input  pbl_pkg::t_fcell_ctrl         i_ctrl,
    output pbl_pkg::t_fcell_stat         o_stat
);

    logic                         r_valid;
    logic                         r_dirty;
    logic                         r_in_lru;
    logic [pbl_pkg::PIN_BITS-1:0] r_pin;
    logic [pbl_pkg::PAGE_W-1:0]   r_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_dirty  <= 1'b0;
            r_in_lru <= 1'b1;
            r_pin    <= '0;
        end else begin
            if (i_ctrl.install) begin
                r_valid <= 1'b1;
                r_pin   <= pbl_pkg::PIN_BITS'(1);
                r_dirty <= 1'b0;
            end else begin
                if (i_ctrl.drop) r_valid <= 1'b0;
                if (i_ctrl.pin_inc) r_pin <= r_pin + 1'b1;
                else if (i_ctrl.pin_dec) r_pin <= r_pin - 1'b1;
                if (i_ctrl.set_dirty) r_dirty <= 1'b1;
                else if (i_ctrl.clr_dirty) r_dirty <= 1'b0;
            end
            if (i_ctrl.q_out) r_in_lru <= 1'b0;
            else if (i_ctrl.q_in) r_in_lru <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.install) r_page <= i_page;
    end

    assign o_stat.valid  = r_valid;
    assign o_stat.dirty  = r_dirty;
    assign o_stat.in_lru = r_in_lru;
    assign o_stat.pin    = r_pin;
    assign o_stat.page   = r_page;
    assign o_stat.match  = r_valid && (r_page == i_page);

endmodule

@@ rtl/core/pbl_queue_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_queue_cell: one slot of the LRU queue
// Takes its right neighbor's frame on removal, or a pushed frame on load.
// ----------------------------------------------------------------------------
module pbl_queue_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pbl_pkg::FIDX_W-1:0]   i_rst_id,
    input  logic                         i_shift,
    input  logic [pbl_pkg::FIDX_W-1:0]   i_right,
    input  logic                         i_load,
    input  logic [pbl_pkg::FIDX_W-1:0]   i_load_id,
    output logic [pbl_pkg::FIDX_W-1:0]   o_id
);

    logic [pbl_pkg::FIDX_W-1:0] r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= i_rst_id;
        end else if (i_shift) begin
            r_id <= i_right;
        end else if (i_load) begin
            r_id <= i_load_id;
        end
    end

    assign o_id = r_id;

endmodule

@@ rtl/core/page_buffer_pool_lru.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_buffer_pool_lru: buffer pool page map with LRU replacement
// Fully associative page-to-frame map with pin counts, dirty marks and an
// LRU queue of unpinned frames, built as a row of frame cells and a chain
// of queue cells that shift toward the head on removal.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start, busy          | i_op, i_page_id, i_mark_dirty
//  result    | o_strobe (1 cycle)   | o_kind, o_page_number, o_frame, o_ok,
//            |                      | o_last
//
//  A request is taken when start is high and busy is low; busy drops in the
//  cycle that shows its completion. A hit, refusal or unpin completes from
//  the look-up and act states; a flush of one page adds a done state, a
//  fetch/new miss a command and a done state, and a flush of all a walk
//  over the frame cells (one frame per cycle) before the done state. Each
//  result is held one cycle; the receiver cannot stall. Synchronous
//  active-low reset empties the map and queues all frames in index order.
// ----------------------------------------------------------------------------
module page_buffer_pool_lru (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_op,
    input  logic [pbl_pkg::PAGE_W-1:0]     i_page_id,
    input  logic                           i_mark_dirty,
    output logic                           o_strobe,
    output logic [1:0]                     o_kind,
    output logic [pbl_pkg::PAGE_W-1:0]     o_page_number,
    output logic [pbl_pkg::FRAME_W-1:0]    o_frame,
    output logic                           o_ok,
    output logic                           o_last
);

    localparam int NF = pbl_pkg::FRAMES;
    localparam int FW = pbl_pkg::FIDX_W;
    localparam int LW = pbl_pkg::LEN_W;

    // control and request registers
    pbl_pkg::t_state             r_state, n_state;
    logic [2:0]                  r_op;
    logic [pbl_pkg::PAGE_W-1:0]  r_page;
    logic                        r_md;
    logic                        r_hit, n_hit;
    logic [FW-1:0]               r_f, n_f;
    logic [FW-1:0]               r_v, n_v;
    logic [FW-1:0]               r_walk, n_walk;
    logic [LW-1:0]               r_len, n_len;
    logic [pbl_pkg::PAGE_W-1:0]  r_done_page, n_done_page;
    logic [FW-1:0]               r_done_frame, n_done_frame;
    logic                        r_done_ok, n_done_ok;

    // result registers
    logic                        r_strobe, n_strobe;
    pbl_pkg::t_kind              r_kind, n_kind;
    logic [pbl_pkg::PAGE_W-1:0]  r_pnum, n_pnum;
    logic [FW-1:0]               r_frame, n_frame;
    logic                        r_ok, n_ok;
    logic                        r_last, n_last;

    // cell wiring
    pbl_pkg::t_fcell_ctrl        cell_ctrl [NF];
    pbl_pkg::t_fcell_stat        cell_stat [NF];
    logic [pbl_pkg::PAGE_W-1:0]  cell_page;
    logic [NF-1:0]               match_vec;
    logic [NF-1:0]               in_lru_vec;
    logic [FW-1:0]               q_id   [NF];
    logic [NF-1:0]               q_shift;
    logic [NF-1:0]               q_load;

    logic                        q_rm;
    logic [FW-1:0]               q_rm_id;
    logic                        q_push;
    logic [FW-1:0]               q_push_id;

    logic                        lk_hit;
    logic [FW-1:0]               lk_f;
    pbl_pkg::t_fcell_stat        st_f, st_v, st_w;
    logic [FW-1:0]               head;

    assign cell_page = (r_state == pbl_pkg::ST_CMD) ? r_page
                     : (r_state == pbl_pkg::ST_LOOK) ? r_page : r_page;

    genvar g;
    generate
        for (g = 0; g < NF; g++) begin : g_frame
            pbl_frame_cell u_frame (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_page  (cell_page),
                .i_ctrl  (cell_ctrl[g]),
                .o_stat  (cell_stat[g])
            );
            assign match_vec[g]  = cell_stat[g].match;
            assign in_lru_vec[g] = cell_stat[g].in_lru;
        end

        for (g = 0; g < NF; g++) begin : g_queue
            pbl_queue_cell u_queue (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_rst_id  (FW'(g)),
                .i_shift   (q_shift[g]),
                .i_right   ((g == NF - 1) ? q_id[g] : q_id[(g + 1) % NF]),
                .i_load    (q_load[g]),
                .i_load_id (q_push_id),
                .o_id      (q_id[g])
            );
        end
    endgenerate

    // queue chain: a slot shifts once the removed frame lies at or before it
    always_comb begin
        logic pre;
        pre = 1'b0;
        for (int k = 0; k < NF; k++) begin
            pre = pre | ((q_id[k] == q_rm_id) && (LW'(k) < r_len));
            q_shift[k] = q_rm && pre;
            q_load[k]  = q_push && (LW'(k) == r_len);
        end
    end

    // lowest matching frame
    always_comb begin
        lk_hit = 1'b0;
        lk_f   = '0;
        for (int k = NF - 1; k >= 0; k--) begin
            if (match_vec[k]) begin
                lk_hit = 1'b1;
                lk_f   = FW'(k);
            end
        end
    end

    assign head = q_id[0];
    assign st_f = cell_stat[r_f];
    assign st_v = cell_stat[head];
    assign st_w = cell_stat[r_walk];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pbl_pkg::ST_IDLE;
            r_len    <= LW'(NF);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op   <= i_op;
            r_page <= i_page_id;
            r_md   <= i_mark_dirty;
        end
        r_hit        <= n_hit;
        r_f          <= n_f;
        r_v          <= n_v;
        r_walk       <= n_walk;
        r_done_page  <= n_done_page;
        r_done_frame <= n_done_frame;
        r_done_ok    <= n_done_ok;
        r_kind       <= n_kind;
        r_pnum       <= n_pnum;
        r_frame      <= n_frame;
        r_ok         <= n_ok;
        r_last       <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_hit        = r_hit;
        n_f          = r_f;
        n_v          = r_v;
        n_walk       = r_walk;
        n_len        = r_len;
        n_done_page  = r_done_page;
        n_done_frame = r_done_frame;
        n_done_ok    = r_done_ok;
        n_strobe     = 1'b0;
        n_kind       = r_kind;
        n_pnum       = r_pnum;
        n_frame      = r_frame;
        n_ok         = r_ok;
        n_last       = r_last;
        q_rm         = 1'b0;
        q_rm_id      = '0;
        q_push       = 1'b0;
        q_push_id    = '0;
        for (int k = 0; k < NF; k++) cell_ctrl[k] = '0;

        unique case (r_state)
            pbl_pkg::ST_IDLE: begin
                if (start) n_state = pbl_pkg::ST_LOOK;
            end
            pbl_pkg::ST_LOOK: begin
                n_hit   = lk_hit;
                n_f     = lk_f;
                n_state = pbl_pkg::ST_ACT;
            end
            pbl_pkg::ST_ACT: begin
                // default outcome: completion straight from here
                n_strobe = 1'b1;
                n_kind   = pbl_pkg::K_DONE;
                n_pnum   = r_page;
                n_frame  = '0;
                n_ok     = 1'b0;
                n_last   = 1'b1;
                n_state  = pbl_pkg::ST_IDLE;
                case (r_op) inside
                    pbl_pkg::OP_FETCH, pbl_pkg::OP_NEW: begin
                        if (r_hit && (r_op == pbl_pkg::OP_NEW)) begin
                            n_frame = r_f;
                        end else if (r_hit) begin
                            n_frame = r_f;
                            if (st_f.pin != pbl_pkg::PIN_MAX) begin
                                n_ok = 1'b1;
                                cell_ctrl[r_f].pin_inc = 1'b1;
                                if (st_f.in_lru) begin
                                    cell_ctrl[r_f].q_out = 1'b1;
                                    q_rm    = 1'b1;
                                    q_rm_id = r_f;
                                    n_len   = r_len - 1'b1;
                                end
                            end
                        end else if (r_len != '0) begin
                            // evict queue head
                            n_strobe = 1'b0;
                            n_v      = head;
                            q_rm     = 1'b1;
                            q_rm_id  = head;
                            n_len    = r_len - 1'b1;
                            cell_ctrl[head].q_out = 1'b1;
                            cell_ctrl[head].drop  = 1'b1;
                            if (st_v.valid && st_v.dirty) begin
                                n_strobe = 1'b1;
                                n_kind   = pbl_pkg::K_WRITE;
                                n_pnum   = st_v.page;
                                n_frame  = head;
                                n_last   = 1'b0;
                            end
                            n_state = pbl_pkg::ST_CMD;
                        end
                    end
                    pbl_pkg::OP_UNPIN: begin
                        if (r_hit) begin
                            n_frame = r_f;
                            if (st_f.pin != '0) begin
                                n_ok = 1'b1;
                                cell_ctrl[r_f].pin_dec   = 1'b1;
                                cell_ctrl[r_f].set_dirty = r_md;
                                if ((st_f.pin == pbl_pkg::PIN_BITS'(1)) && !st_f.in_lru) begin
                                    cell_ctrl[r_f].q_in = 1'b1;
                                    q_push    = 1'b1;
                                    q_push_id = r_f;
                                    n_len     = r_len + 1'b1;
                                end
                            end
                        end
                    end
                    pbl_pkg::OP_FLUSH: begin
                        if (r_hit) begin
                            n_kind       = pbl_pkg::K_WRITE;
                            n_frame      = r_f;
                            n_last       = 1'b0;
                            cell_ctrl[r_f].clr_dirty = 1'b1;
                            n_done_page  = r_page;
                            n_done_frame = r_f;
                            n_done_ok    = 1'b1;
                            n_state      = pbl_pkg::ST_DONE;
                        end
                    end
                    pbl_pkg::OP_FLUSH_ALL: begin
                        n_strobe = 1'b0;
                        n_walk   = '0;
                        n_state  = pbl_pkg::ST_FLUSH;
                    end
                    default: begin
                    end
                endcase
            end
            pbl_pkg::ST_CMD: begin
                cell_ctrl[r_v].install = 1'b1;
                n_strobe     = 1'b1;
                n_kind       = (r_op == pbl_pkg::OP_NEW) ? pbl_pkg::K_INIT : pbl_pkg::K_READ;
                n_pnum       = r_page;
                n_frame      = r_v;
                n_ok         = 1'b0;
                n_last       = 1'b0;
                n_done_page  = r_page;
                n_done_frame = r_v;
                n_done_ok    = 1'b1;
                n_state      = pbl_pkg::ST_DONE;
            end
            pbl_pkg::ST_FLUSH: begin
                if (st_w.valid && st_w.dirty) begin
                    cell_ctrl[r_walk].clr_dirty = 1'b1;
                    n_strobe = 1'b1;
                    n_kind   = pbl_pkg::K_WRITE;
                    n_pnum   = st_w.page;
                    n_frame  = r_walk;
                    n_ok     = 1'b0;
                    n_last   = 1'b0;
                end
                if (r_walk == FW'(NF - 1)) begin
                    n_done_page  = '0;
                    n_done_frame = '0;
                    n_done_ok    = 1'b1;
                    n_state      = pbl_pkg::ST_DONE;
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end
            pbl_pkg::ST_DONE: begin
                n_strobe = 1'b1;
                n_kind   = pbl_pkg::K_DONE;
                n_pnum   = r_done_page;
                n_frame  = r_done_frame;
                n_ok     = r_done_ok;
                n_last   = 1'b1;
                n_state  = pbl_pkg::ST_IDLE;
            end
            default: n_state = pbl_pkg::ST_IDLE;
        endcase
    end

    // busy also covers a non-final result in the result register, so the next
    // request is taken no earlier than the cycle that shows the completion
    assign busy          = (r_state != pbl_pkg::ST_IDLE) || (r_strobe && !r_last);
    assign o_strobe      = r_strobe;
    assign o_kind        = r_kind;
    assign o_page_number = r_pnum;
    assign o_frame       = pbl_pkg::FRAME_W'(r_frame);
    assign o_ok          = r_ok;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(NF))
        else $error("queue length beyond frame count");
    a_len_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(in_lru_vec) == 32'(r_len))
        else $error("queue length disagrees with membership bits");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result right after a completion");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: page buffer pool with LRU replacement
// Directed and random requests go through the start/busy port. A local model
// of the page map, pin counts, dirty marks and LRU queue predicts every command
// and completion, and each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NF = pbl_pkg::FRAMES;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [pbl_pkg::PAGE_W-1:0]  page;
        logic [pbl_pkg::FRAME_W-1:0] frame;
        logic                        ok;
        logic                        last;
    } t_res;

    logic i_clk = 0, i_rst_n = 0, start = 0, i_mark_dirty = 0;
    logic [2:0] i_op = 0;
    logic [pbl_pkg::PAGE_W-1:0] i_page_id = 0;
    logic busy, o_strobe, o_ok, o_last;
    logic [1:0] o_kind;
    logic [pbl_pkg::PAGE_W-1:0] o_page_number;
    logic [pbl_pkg::FRAME_W-1:0] o_frame;

    page_buffer_pool_lru uut (.*);

    always #10 i_clk = ~i_clk;

    // pool model
    logic [pbl_pkg::PAGE_W-1:0]   m_page [NF];
    logic                         m_valid[NF];
    logic [pbl_pkg::PIN_BITS-1:0] m_pin  [NF];
    logic                         m_dirty[NF];
    int                           m_queue[$];
    t_res                         pending[$];
    int                           n_fail = 0;
    int                           idle_pct = 0;
    longint                       cycles = 0;
    logic [pbl_pkg::PAGE_W-1:0]   pages_used[$];

    function automatic int find_frame(logic [pbl_pkg::PAGE_W-1:0] p);
        for (int f = 0; f < NF; f++)
            if (m_valid[f] && m_page[f] == p) return f;
        return -1;
    endfunction

    function automatic void queue_drop(int f);
        foreach (m_queue[i])
            if (m_queue[i] == f) begin
                m_queue.delete(i);
                return;
            end
    endfunction

    function automatic void post(pbl_pkg::t_kind k, logic [pbl_pkg::PAGE_W-1:0] p,
                                 int f, bit ok, bit l);
        t_res r;
        r = '{k, p, pbl_pkg::FRAME_W'(f), ok, l};
        pending = {pending, r};
    endfunction

    function automatic void predict_pool(logic [2:0] op, logic [pbl_pkg::PAGE_W-1:0] p,
                                         bit d);
        int f, v;
        f = find_frame(p);
        case (op)
            pbl_pkg::OP_FETCH, pbl_pkg::OP_NEW: begin
                if (f >= 0) begin
                    if (op == pbl_pkg::OP_NEW || m_pin[f] == pbl_pkg::PIN_MAX)
                        post(pbl_pkg::K_DONE, p, f, 0, 1);
                    else begin
                        m_pin[f]++;
                        queue_drop(f);
                        post(pbl_pkg::K_DONE, p, f, 1, 1);
                    end
                end else if (m_queue.size() == 0) post(pbl_pkg::K_DONE, p, 0, 0, 1);
                else begin
                    v = m_queue[0];
                    m_queue.delete(0);
                    if (m_valid[v] && m_dirty[v]) post(pbl_pkg::K_WRITE, m_page[v], v, 0, 0);
                    m_valid[v] = 1; m_page[v] = p; m_pin[v] = 1; m_dirty[v] = 0;
                    post(op == pbl_pkg::OP_FETCH ? pbl_pkg::K_READ : pbl_pkg::K_INIT,
                         p, v, 0, 0);
                    post(pbl_pkg::K_DONE, p, v, 1, 1);
                end
            end
            pbl_pkg::OP_UNPIN: begin
                if (f < 0) post(pbl_pkg::K_DONE, p, 0, 0, 1);
                else if (m_pin[f] == 0) post(pbl_pkg::K_DONE, p, f, 0, 1);
                else begin
                    if (d) m_dirty[f] = 1;
                    m_pin[f]--;
                    if (m_pin[f] == 0) m_queue = {m_queue, f};
                    post(pbl_pkg::K_DONE, p, f, 1, 1);
                end
            end
            pbl_pkg::OP_FLUSH: begin
                if (f < 0) post(pbl_pkg::K_DONE, p, 0, 0, 1);
                else begin
                    post(pbl_pkg::K_WRITE, p, f, 0, 0);
                    m_dirty[f] = 0;
                    post(pbl_pkg::K_DONE, p, f, 1, 1);
                end
            end
            pbl_pkg::OP_FLUSH_ALL: begin
                for (int g = 0; g < NF; g++)
                    if (m_valid[g] && m_dirty[g]) begin
                        post(pbl_pkg::K_WRITE, m_page[g], g, 0, 0);
                        m_dirty[g] = 0;
                    end
                post(pbl_pkg::K_DONE, 0, 0, 1, 1);
            end
            default: post(pbl_pkg::K_DONE, p, 0, 0, 1);
        endcase
    endfunction

    // result checker: strobe is one cycle, sampled at the rising edge
    always @(posedge i_clk) begin
        t_res got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            got = '{o_kind, o_page_number, o_frame, o_ok, o_last};
            if (pending.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending[0];
                pending.delete(0);
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // one request: optional idle gap, then hold start until accepted
    task automatic send_request(logic [2:0] op, logic [pbl_pkg::PAGE_W-1:0] p, bit d);
        if ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        end
        i_op <= op; i_page_id <= p; i_mark_dirty <= d; start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_pool(op, p, d);
        if (p != 0 && op != pbl_pkg::OP_FLUSH_ALL) pages_used = {pages_used, p};
        @(negedge i_clk);
    endtask

    task automatic drain_pool();
        start <= 0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (NF + 8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_request(pbl_pkg::OP_UNPIN, 32'h1, 1);          // not resident
        send_request(pbl_pkg::OP_FLUSH, 32'hFFFF_FFFF, 0);  // not resident
        send_request(pbl_pkg::OP_FETCH, 32'hFFFF_FFFF, 0);
        send_request(pbl_pkg::OP_FETCH, 32'h0, 0);
        send_request(pbl_pkg::OP_NEW, 32'h0, 0);            // already resident
        send_request(pbl_pkg::OP_NEW, 32'hA5A5_5A5A, 0);
        send_request(pbl_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1);
        send_request(pbl_pkg::OP_UNPIN, 32'hFFFF_FFFF, 0);  // unpin at zero pins
        send_request(pbl_pkg::OP_FLUSH, 32'h0, 0);
        send_request(pbl_pkg::OP_UNPIN, 32'hA5A5_5A5A, 1);
        send_request(pbl_pkg::OP_FLUSH_ALL, 32'h1234, 0);
        send_request(3'd5, 32'h7, 1);
        send_request(3'd6, 32'h8, 0);
        send_request(3'd7, 32'h9, 1);
        // fill every frame pinned so no victim is left
        for (int i = 0; i < NF; i++) send_request(pbl_pkg::OP_NEW, 32'h100 + i, 0);
        send_request(pbl_pkg::OP_FETCH, 32'h5000, 0);
        send_request(pbl_pkg::OP_NEW, 32'h5001, 0);
        // stack several pins on one frame
        for (int i = 0; i < 4; i++) send_request(pbl_pkg::OP_FETCH, 32'h100, 0);
        for (int i = 0; i < NF; i++) send_request(pbl_pkg::OP_UNPIN, 32'h100 + i, 1'(i & 1));
        for (int i = 0; i < 6; i++) send_request(pbl_pkg::OP_UNPIN, 32'h100, $urandom_range(1));
        send_request(pbl_pkg::OP_FLUSH_ALL, 32'h0, 0);
        drain_pool();
    endtask

    task automatic test_random(int count);
        logic [pbl_pkg::PAGE_W-1:0] p;
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            // mostly a small working set so hits, evictions and unpins occur
            if ($urandom_range(9) < 8 && pages_used.size() > 0 && $urandom_range(1))
                p = pages_used[$urandom_range(pages_used.size() - 1)];
            else if ($urandom_range(9) < 8) p = $urandom_range(40);
            else p = $urandom;
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(pbl_pkg::OP_FLUSH_ALL));
            send_request(op, p, $urandom_range(1));
        end
        drain_pool();
    endtask

    initial begin
        foreach (m_valid[f]) begin
            m_valid[f] = 0; m_page[f] = 0; m_pin[f] = 0; m_dirty[f] = 0;
            m_queue = {m_queue, f};
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_directed();
        idle_pct = 0;  test_random(38);
        idle_pct = 70; test_random(38);
        idle_pct = 17; test_random(38);
        idle_pct = 0;  test_random(38);
        if (n_fail == 0 && pending.size() == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk)
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
endmodule
